// ----- rtl/assert_macros.svh -----
// assertion helpers for the lcd write sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lcd4_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_pkg
// shared types and constants of the four-bit lcd write sequencer
// ----------------------------------------------------------------------------
package lcd4_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_INSTR = 2'd1,
		CMD_DATA  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	localparam logic [7:0] POWER_UP_TICKS_RST = 8'd50;
	localparam logic [7:0] PHASE_TICKS_RST    = 8'd1;

	localparam logic [2:0] INIT_STEP_CLEAR = 3'd3;
	localparam logic [2:0] INIT_STEP_ENTRY = 3'd4;
	localparam logic [2:0] INIT_STEP_DONE  = 3'd5;

	// register map, word index
	localparam logic REG_POWER_UP_TICKS = 1'b0;
	localparam logic REG_PHASE_TICKS    = 1'b1;

	// init instruction for each step
	function automatic logic [7:0] init_byte(input logic [2:0] step);
		logic [7:0] b;
		case (step)
			3'd0:    b = 8'h02;
			3'd1:    b = 8'h28;
			3'd2:    b = 8'h0C;
			3'd3:    b = 8'h01;
			default: b = 8'h06;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/lcd4_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd4_req_if / lcd4_res_if
// request and result channels of the lcd write sequencer
// ----------------------------------------------------------------------------
interface lcd4_req_if import lcd4_pkg::*; ();
	logic       valid;
	logic       ready;
	cmd_t       command;
	logic [7:0] byte_value;

	modport source (output valid, output command, output byte_value, input ready);
	modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface lcd4_res_if import lcd4_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       rs_pin;
	logic       enable_pin;
	logic [3:0] data_nibble;
	logic       busy_res;
	logic       init_done;
	logic       rejected;

	modport source (output valid, output rs_pin, output enable_pin, output data_nibble,
		output busy_res, output init_done, output rejected, input ready);
	modport sink   (input valid, input rs_pin, input enable_pin, input data_nibble,
		input busy_res, input init_done, input rejected, output ready);
endinterface

// ----- rtl/lcd_four_bit_write_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_four_bit_write_sequencer
// hd44780-style four-bit character lcd write sequencer
// ----------------------------------------------------------------------------
// Drives a character lcd over a four-bit bus. Time advances only through tick
// requests (command 0); each tick is one time unit of the lcd timing. After
// reset the block waits power_up_ticks ticks, then sends the init instructions
// 0x02, 0x28, 0x0C, 0x01, waits one extra phase after the clear and sends
// 0x06, after which init_done rises. Every byte goes out in four phases of
// phase_ticks ticks: high nibble with enable high, enable low, low nibble with
// enable high, enable low; rs is held for the whole byte. Write requests
// (command 1 instruction, command 2 data) start at once when the block is idle
// and initialised; otherwise they are dropped and the result flags rejected.
// Command 3 is ignored. Every request yields exactly one result, showing the
// pin levels and status after that request. Throughput is one request per
// clock while the result channel takes results: a request is captured in an
// input register, then one pass of logic updates the sequencer state, whose
// registers are the result. Registers are written over the apb port (0x0
// power_up_ticks, 0x4 phase_ticks) only while no request is pending; the user
// must keep to it, the block does not enforce it. A phase_ticks of 0 acts as 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_four_bit_write_sequencer import lcd4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// channels
	lcd4_req_if.sink    req,
	lcd4_res_if.source  res
);

	// one-hot sequencer phases
	typedef enum logic [6:0] {
		PH_POWER   = 7'b0000001,
		PH_IDLE    = 7'b0000010,
		PH_HI_EN   = 7'b0000100,
		PH_HI_OFF  = 7'b0001000,
		PH_LO_EN   = 7'b0010000,
		PH_LO_OFF  = 7'b0100000,
		PH_CLR_GAP = 7'b1000000
	} phase_t;

	// configuration registers
	logic [7:0] power_up_ticks_q;
	logic [7:0] phase_ticks_q;

	// input register
	logic       req_valid_s1;
	cmd_t       req_cmd_s1;
	logic [7:0] req_byte_s1;

	// sequencer state, doubles as the result register
	phase_t     phase_q,       phase_n;
	logic [7:0] hold_count_q,  hold_count_n;
	logic [7:0] held_byte_q,   held_byte_n;
	logic       held_select_q, held_select_n;
	logic [2:0] init_step_q,   init_step_n;
	logic       init_fin_q,    init_fin_n;
	logic       pin_rs_q,      pin_rs_n;
	logic       pin_en_q,      pin_en_n;
	logic [3:0] pin_nib_q,     pin_nib_n;
	logic       res_valid_s2;
	logic       rejected_s2,   rejected_n;

	// helpers of the update logic
	logic       advance;
	logic       cfg_write;
	logic [7:0] limit;
	logic [7:0] hold_inc;
	logic       phase_end;
	logic       start_byte;
	logic [7:0] start_val;
	logic       start_sel;

	// ------------------------------------------------------------------------
	// apb configuration port, zero wait states
	// ------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_ticks_q <= POWER_UP_TICKS_RST;
			phase_ticks_q    <= PHASE_TICKS_RST;
		end else if (cfg_write) begin
			if (paddr[2] == REG_PHASE_TICKS) begin
				phase_ticks_q <= pwdata[7:0];
			end else begin
				power_up_ticks_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POWER_UP_TICKS: prdata = {24'd0, power_up_ticks_q};
			REG_PHASE_TICKS:    prdata = {24'd0, phase_ticks_q};
			default:            prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------------
	// flow control: the held request moves on once the result slot is free
	// ------------------------------------------------------------------------
	assign advance   = req_valid_s1 && (!res_valid_s2 || res.ready);
	assign req.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_cmd_s1  <= req.command;
			req_byte_s1 <= req.byte_value;
		end
	end

	// ------------------------------------------------------------------------
	// sequencer update for one request
	// ------------------------------------------------------------------------
	assign limit     = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
	assign hold_inc  = hold_count_q + 8'd1;
	// hold_count stays below limit inside a phase, so the increment never wraps
	assign phase_end = (hold_inc >= limit);

	always_comb begin
		phase_n       = phase_q;
		hold_count_n  = hold_count_q;
		held_byte_n   = held_byte_q;
		held_select_n = held_select_q;
		init_step_n   = init_step_q;
		init_fin_n    = init_fin_q;
		pin_rs_n      = pin_rs_q;
		pin_en_n      = pin_en_q;
		pin_nib_n     = pin_nib_q;
		rejected_n    = 1'b0;
		start_byte    = 1'b0;
		start_val     = 8'd0;
		start_sel     = 1'b0;

		case (req_cmd_s1) inside
			CMD_TICK: begin
				unique case (phase_q)
					PH_POWER: begin
						// count out the power-up delay, then send the first instruction
						if (hold_count_q >= power_up_ticks_q) begin
							init_step_n = 3'd0;
							start_byte  = 1'b1;
							start_val   = init_byte(3'd0);
						end else begin
							hold_count_n = hold_inc;
						end
					end
					PH_IDLE: begin
					end
					PH_HI_EN: begin
						hold_count_n = phase_end ? 8'd0 : hold_inc;
						if (phase_end) begin
							pin_en_n = 1'b0;
							phase_n  = PH_HI_OFF;
						end
					end
					PH_HI_OFF: begin
						hold_count_n = phase_end ? 8'd0 : hold_inc;
						if (phase_end) begin
							pin_nib_n = held_byte_q[3:0];
							pin_en_n  = 1'b1;
							phase_n   = PH_LO_EN;
						end
					end
					PH_LO_EN: begin
						hold_count_n = phase_end ? 8'd0 : hold_inc;
						if (phase_end) begin
							pin_en_n = 1'b0;
							phase_n  = PH_LO_OFF;
						end
					end
					PH_LO_OFF: begin
						hold_count_n = phase_end ? 8'd0 : hold_inc;
						if (phase_end) begin
							// byte done: go idle or step through the init list
							if (init_fin_q) begin
								phase_n = PH_IDLE;
							end else if (init_step_q == INIT_STEP_CLEAR) begin
								// the clear instruction gets an extra gap phase
								init_step_n = INIT_STEP_ENTRY;
								phase_n     = PH_CLR_GAP;
							end else if (init_step_q >= INIT_STEP_ENTRY) begin
								init_step_n = INIT_STEP_DONE;
								init_fin_n  = 1'b1;
								phase_n     = PH_IDLE;
							end else begin
								init_step_n = init_step_q + 3'd1;
								start_byte  = 1'b1;
								start_val   = init_byte(init_step_q + 3'd1);
							end
						end
					end
					PH_CLR_GAP: begin
						hold_count_n = phase_end ? 8'd0 : hold_inc;
						if (phase_end) begin
							start_byte = 1'b1;
							start_val  = init_byte(INIT_STEP_ENTRY);
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
			CMD_INSTR, CMD_DATA: begin
				if (phase_q != PH_IDLE) begin
					rejected_n = 1'b1;
				end else begin
					start_byte = 1'b1;
					start_val  = req_byte_s1;
					start_sel  = (req_cmd_s1 == CMD_DATA);
				end
			end
			default: begin
				// reserved command: no effect
			end
		endcase

		// first phase of a new byte: high nibble with enable high
		if (start_byte) begin
			held_byte_n   = start_val;
			held_select_n = start_sel;
			phase_n       = PH_HI_EN;
			hold_count_n  = 8'd0;
			pin_rs_n      = start_sel;
			pin_nib_n     = start_val[7:4];
			pin_en_n      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_POWER;
			hold_count_q  <= 8'd0;
			held_byte_q   <= 8'd0;
			held_select_q <= 1'b0;
			init_step_q   <= 3'd0;
			init_fin_q    <= 1'b0;
			pin_rs_q      <= 1'b0;
			pin_en_q      <= 1'b0;
			pin_nib_q     <= 4'd0;
			rejected_s2   <= 1'b0;
			res_valid_s2  <= 1'b0;
		end else begin
			if (advance) begin
				phase_q       <= phase_n;
				hold_count_q  <= hold_count_n;
				held_byte_q   <= held_byte_n;
				held_select_q <= held_select_n;
				init_step_q   <= init_step_n;
				init_fin_q    <= init_fin_n;
				pin_rs_q      <= pin_rs_n;
				pin_en_q      <= pin_en_n;
				pin_nib_q     <= pin_nib_n;
				rejected_s2   <= rejected_n;
				res_valid_s2  <= 1'b1;
			end else if (res.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result channel: the state registers are the result
	// ------------------------------------------------------------------------
	assign res.valid       = res_valid_s2;
	assign res.rs_pin      = pin_rs_q;
	assign res.enable_pin  = pin_en_q;
	assign res.data_nibble = pin_nib_q;
	assign res.busy_res    = (phase_q != PH_IDLE);
	assign res.init_done   = init_fin_q;
	assign res.rejected    = rejected_s2;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	`ASSERT_SAME(a_rej_busy, clk, arst_n, res.valid && res.rejected, res.busy_res,
		"rejected request while sequencer idle")
	`ASSERT_NEXT(a_init_sticky, clk, arst_n, init_fin_q, init_fin_q,
		"init_done fell")
	`ASSERT_SAME(a_en_phase, clk, arst_n, 1'b1,
		pin_en_q == ((phase_q == PH_HI_EN) || (phase_q == PH_LO_EN)),
		"enable level does not match phase")
	`ASSERT_SAME(a_stall_cause, clk, arst_n, !req.ready, res.valid && !res.ready,
		"request stalled without a stalled result")

endmodule
